// ===== src/scs_pkg.sv =====
package scs_pkg;

  localparam int COORD_W    = 24;                  // Q16.8 coordinate
  localparam int DIFF_W     = COORD_W + 1;         // endpoint / center differences
  localparam int SQ_W       = 2 * DIFF_W;          // product of two differences
  localparam int RAD_W      = 23;                  // radius
  localparam int A_W        = SQ_W;                // squared segment length
  localparam int B_W        = SQ_W + 1;            // d.p, signed
  localparam int C_W        = SQ_W + 1;            // |p|^2 - r^2, signed
  localparam int MAG_W      = SQ_W;                // magnitudes of b and c
  localparam int HALF_W     = MAG_W / 2;           // partial product operand
  localparam int WIDE_W     = 2 * MAG_W;           // b*b, a*c, discriminant
  localparam int ROOT_W     = WIDE_W / 2 + 1;      // integer square root
  localparam int N_W        = ROOT_W + 2;          // -b +/- s, signed
  localparam int LIM_W      = 32;                  // limit registers
  localparam int FRAC_W     = 16;                  // alpha fraction bits
  localparam int ALPHA_W    = FRAC_W + 1;          // alpha, 0..1.0 inclusive
  localparam int LERP_W     = ALPHA_W + 1 + DIFF_W; // alpha * difference
  localparam int CNT_W      = 2;
  localparam int IN_W       = 4 * COORD_W;
  localparam int OUT_FLD_W  = CNT_W + 2 * ALPHA_W + 4 * COORD_W;
  localparam int OUT_W      = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  localparam logic [ALPHA_W-1:0] HALF_ALPHA = ALPHA_W'(1) << (FRAC_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_RADIUS,
    CFG_TANGENT_LIMIT,
    CFG_SHORT_LIMIT
  } cfg_idx_t;

  // segment geometry carried to the point interpolation
  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [DIFF_W-1:0]  dx;
    logic [DIFF_W-1:0]  dy;
  } seg_t;

  // side data traveling with the square root
  typedef struct packed {
    logic [A_W-1:0] a;
    logic [B_W-1:0] b;
    logic           neg;
    logic           tang;
    seg_t           seg;
  } sq_pay_t;

  // side data traveling with the divider
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             half;
    seg_t             seg;
  } dv_pay_t;

endpackage

// ===== src/scs_sqrt.sv =====
module scs_sqrt #(
  parameter int ROOT_W = scs_pkg::ROOT_W,
  parameter int PAY_W  = $bits(scs_pkg::sq_pay_t)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ce,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   in_rad,
  input  logic [PAY_W-1:0]      in_pay,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     out_root,
  output logic [PAY_W-1:0]      out_pay
);

  localparam int VAL_W = 2 * ROOT_W;

  logic [VAL_W-1:0]  rem_q [ROOT_W];
  logic [ROOT_W-1:0] res_q [ROOT_W];
  logic [PAY_W-1:0]  pay_q [ROOT_W];
  logic              v_q   [ROOT_W];

  // one root bit per stage, most significant first
  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam int Bit = ROOT_W - 1 - k;
    logic [VAL_W-1:0]  rem_src;
    logic [ROOT_W-1:0] res_src;
    logic [PAY_W-1:0]  pay_src;
    logic              v_src;
    logic [VAL_W:0]    trial;
    logic              take;

    if (k == 0) begin : g_head
      assign rem_src = in_rad;
      assign res_src = '0;
      assign pay_src = in_pay;
      assign v_src   = in_valid;
    end else begin : g_tail
      assign rem_src = rem_q[k-1];
      assign res_src = res_q[k-1];
      assign pay_src = pay_q[k-1];
      assign v_src   = v_q[k-1];
    end

    // (res + 2^Bit)^2 - res^2 = res*2^(Bit+1) + 2^(2*Bit)
    assign trial = ((VAL_W+1)'(res_src) << (Bit + 1)) | ((VAL_W+1)'(1) << (2 * Bit));
    assign take  = {1'b0, rem_src} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (ce) begin
        v_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_q[k] <= take ? VAL_W'({1'b0, rem_src} - trial) : rem_src;
        res_q[k] <= take ? (res_src | (ROOT_W'(1) << Bit)) : res_src;
        pay_q[k] <= pay_src;
      end
    end
  end

  assign out_valid = v_q[ROOT_W-1];
  assign out_root  = res_q[ROOT_W-1];
  assign out_pay   = pay_q[ROOT_W-1];

endmodule

// ===== src/scs_div.sv =====
module scs_div #(
  parameter int NUM_W = scs_pkg::A_W,
  parameter int QUO_W = scs_pkg::FRAC_W,
  parameter int PAY_W = $bits(scs_pkg::dv_pay_t)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  logic               in_valid,
  input  logic [NUM_W-1:0]   in_num0,
  input  logic [NUM_W-1:0]   in_num1,
  input  logic [NUM_W-1:0]   in_den,
  input  logic [PAY_W-1:0]   in_pay,
  output logic               out_valid,
  output logic [QUO_W:0]     out_q0,
  output logic [QUO_W:0]     out_q1,
  output logic [PAY_W-1:0]   out_pay
);

  logic [NUM_W:0]   rem0_q [QUO_W];
  logic [NUM_W:0]   rem1_q [QUO_W];
  logic [QUO_W-1:0] quo0_q [QUO_W];
  logic [QUO_W-1:0] quo1_q [QUO_W];
  logic             full0_q[QUO_W];
  logic             full1_q[QUO_W];
  logic [NUM_W-1:0] den_q  [QUO_W];
  logic [PAY_W-1:0] pay_q  [QUO_W];
  logic             v_q    [QUO_W];

  // restoring division, one quotient bit per stage for both lanes
  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [NUM_W:0]   rem0_src, rem1_src, sh0, sh1;
    logic [QUO_W-1:0] quo0_src, quo1_src;
    logic             full0_src, full1_src, ge0, ge1, v_src;
    logic [NUM_W-1:0] den_src;
    logic [PAY_W-1:0] pay_src;

    if (k == 0) begin : g_head
      assign rem0_src  = {1'b0, in_num0};
      assign rem1_src  = {1'b0, in_num1};
      assign quo0_src  = '0;
      assign quo1_src  = '0;
      assign full0_src = in_num0 >= in_den;
      assign full1_src = in_num1 >= in_den;
      assign den_src   = in_den;
      assign pay_src   = in_pay;
      assign v_src     = in_valid;
    end else begin : g_tail
      assign rem0_src  = rem0_q[k-1];
      assign rem1_src  = rem1_q[k-1];
      assign quo0_src  = quo0_q[k-1];
      assign quo1_src  = quo1_q[k-1];
      assign full0_src = full0_q[k-1];
      assign full1_src = full1_q[k-1];
      assign den_src   = den_q[k-1];
      assign pay_src   = pay_q[k-1];
      assign v_src     = v_q[k-1];
    end

    assign sh0 = rem0_src << 1;
    assign sh1 = rem1_src << 1;
    assign ge0 = sh0 >= {1'b0, den_src};
    assign ge1 = sh1 >= {1'b0, den_src};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (ce) begin
        v_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem0_q[k]  <= ge0 ? sh0 - {1'b0, den_src} : sh0;
        rem1_q[k]  <= ge1 ? sh1 - {1'b0, den_src} : sh1;
        quo0_q[k]  <= {quo0_src[QUO_W-2:0], ge0};
        quo1_q[k]  <= {quo1_src[QUO_W-2:0], ge1};
        full0_q[k] <= full0_src;
        full1_q[k] <= full1_src;
        den_q[k]   <= den_src;
        pay_q[k]   <= pay_src;
      end
    end
  end

  // a numerator at or above the denominator gives exactly 1.0
  assign out_valid = v_q[QUO_W-1];
  assign out_q0    = full0_q[QUO_W-1] ? ((QUO_W+1)'(1) << QUO_W) : {1'b0, quo0_q[QUO_W-1]};
  assign out_q1    = full1_q[QUO_W-1] ? ((QUO_W+1)'(1) << QUO_W) : {1'b0, quo1_q[QUO_W-1]};
  assign out_pay   = pay_q[QUO_W-1];

endmodule

// ===== src/segment_circle_intersection.sv =====
// Channel  Dir  Payload                                        Handshake
// s_*      in   segment word: start_x, start_y, end_x, end_y   s_tvalid / s_tready
// m_*      out  hits word: count, two alphas, two points      m_tvalid / m_tready
// cfg_*    in   register index + write data                   cfg_valid / cfg_ready
//
// One word enters per cycle while the output is not stalled.
// Most of the depth comes from the 51-stage square root and the 16-stage alpha divider.
// rst is synchronous: it empties the pipeline and loads the register defaults.
// The whole pipeline advances together whenever the output register is empty
// or being taken; a stalled output freezes every stage, nothing is dropped.
module segment_circle_intersection (
  input  logic                                clk,
  input  logic                                rst,
  // start_x [23:0], start_y [47:24], end_x [71:48], end_y [95:72]
  input  logic [scs_pkg::IN_W-1:0]            s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // hit_count [1:0], alpha_first [18:2], alpha_second [35:19], first_x [59:36],
  // first_y [83:60], second_x [107:84], second_y [131:108], zero fill above
  output logic [scs_pkg::OUT_W-1:0]           m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int COORD_W = scs_pkg::COORD_W;
  localparam int DIFF_W  = scs_pkg::DIFF_W;
  localparam int SQ_W    = scs_pkg::SQ_W;
  localparam int RAD_W   = scs_pkg::RAD_W;
  localparam int A_W     = scs_pkg::A_W;
  localparam int B_W     = scs_pkg::B_W;
  localparam int C_W     = scs_pkg::C_W;
  localparam int MAG_W   = scs_pkg::MAG_W;
  localparam int HALF_W  = scs_pkg::HALF_W;
  localparam int WIDE_W  = scs_pkg::WIDE_W;
  localparam int ROOT_W  = scs_pkg::ROOT_W;
  localparam int N_W     = scs_pkg::N_W;
  localparam int LIM_W   = scs_pkg::LIM_W;
  localparam int ALPHA_W = scs_pkg::ALPHA_W;
  localparam int FRAC_W  = scs_pkg::FRAC_W;
  localparam int LERP_W  = scs_pkg::LERP_W;
  localparam int CNT_W   = scs_pkg::CNT_W;
  localparam int PAD_W   = scs_pkg::OUT_W - scs_pkg::OUT_FLD_W;

  // ---------------------------------------------------------------- config
  logic signed [COORD_W-1:0] center_x, center_y;
  logic [RAD_W-1:0]          radius;
  logic [LIM_W-1:0]          tangent_limit, short_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      radius        <= '0;
      tangent_limit <= LIM_W'(1);
      short_limit   <= LIM_W'(1);
    end else if (cfg_valid) begin
      case (scs_pkg::cfg_idx_t'(cfg_index))
        scs_pkg::CFG_CENTER_X:      center_x      <= cfg_data[COORD_W-1:0];
        scs_pkg::CFG_CENTER_Y:      center_y      <= cfg_data[COORD_W-1:0];
        scs_pkg::CFG_RADIUS:        radius        <= cfg_data[RAD_W-1:0];
        scs_pkg::CFG_TANGENT_LIMIT: tangent_limit <= cfg_data[LIM_W-1:0];
        scs_pkg::CFG_SHORT_LIMIT:   short_limit   <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // every stage moves on one common enable
  logic ce;
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;
  logic sq_vo, dv_vo;

  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (ce) begin
      v1 <= s_tvalid;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5; v7 <= v6;
      v8 <= sq_vo;
      v9 <= v8;
      v10 <= dv_vo;
      m_tvalid <= v10;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // d = end - start, p = start - center
  logic signed [COORD_W-1:0] in_sx, in_sy, in_ex, in_ey;
  logic signed [DIFF_W-1:0]  dx1, dy1, px1, py1;
  logic [COORD_W-1:0]        sx1, sy1;

  assign in_sx = s_tdata[COORD_W-1:0];
  assign in_sy = s_tdata[2*COORD_W-1:COORD_W];
  assign in_ex = s_tdata[3*COORD_W-1:2*COORD_W];
  assign in_ey = s_tdata[4*COORD_W-1:3*COORD_W];

  always_ff @(posedge clk) begin
    if (ce) begin
      dx1 <= in_ex - in_sx;
      dy1 <= in_ey - in_sy;
      px1 <= in_sx - center_x;
      py1 <= in_sy - center_y;
      sx1 <= in_sx;
      sy1 <= in_sy;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // all the squares and cross products
  logic signed [SQ_W-1:0] dxx2, dyy2, pxx2, pyy2, dxp2, dyp2;
  logic [2*RAD_W-1:0]     rr2;
  scs_pkg::seg_t          seg2;

  always_ff @(posedge clk) begin
    if (ce) begin
      dxx2    <= dx1 * dx1;
      dyy2    <= dy1 * dy1;
      pxx2    <= px1 * px1;
      pyy2    <= py1 * py1;
      dxp2    <= dx1 * px1;
      dyp2    <= dy1 * py1;
      rr2     <= radius * radius;
      seg2.sx <= sx1;
      seg2.sy <= sy1;
      seg2.dx <= dx1;
      seg2.dy <= dy1;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // a = |d|^2, b = d.p, c = |p|^2 - r^2
  logic [A_W-1:0]        a3;
  logic signed [B_W-1:0] b3;
  logic signed [C_W-1:0] c3;
  scs_pkg::seg_t         seg3;

  always_ff @(posedge clk) begin
    if (ce) begin
      a3   <= dxx2 + dyy2;
      b3   <= dxp2 + dyp2;
      c3   <= pxx2 + pyy2 - $signed({1'b0, rr2});
      seg3 <= seg2;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // magnitudes of b and c for the unsigned wide products
  logic [B_W-1:0]   babs;
  logic [C_W-1:0]   cabs;
  logic [MAG_W-1:0] bm4, cm4;
  logic [A_W-1:0]   a4;
  logic [B_W-1:0]   b4;
  logic             cneg4;
  scs_pkg::seg_t    seg4;

  always_comb begin
    babs = b3[B_W-1] ? -b3 : b3;
    cabs = c3[C_W-1] ? -c3 : c3;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      bm4   <= babs[MAG_W-1:0];
      cm4   <= cabs[MAG_W-1:0];
      cneg4 <= c3[C_W-1];
      a4    <= a3;
      b4    <= b3;
      seg4  <= seg3;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // b*b and a*|c| as half-width partial products
  logic [2*HALF_W-1:0] bhh5, bhl5, bll5, ahh5, ahl5, alh5, all5;
  logic [A_W-1:0]      a5;
  logic [B_W-1:0]      b5;
  logic                cneg5;
  scs_pkg::seg_t       seg5;

  always_ff @(posedge clk) begin
    if (ce) begin
      bhh5  <= bm4[MAG_W-1:HALF_W] * bm4[MAG_W-1:HALF_W];
      bhl5  <= bm4[MAG_W-1:HALF_W] * bm4[HALF_W-1:0];
      bll5  <= bm4[HALF_W-1:0] * bm4[HALF_W-1:0];
      ahh5  <= a4[A_W-1:HALF_W] * cm4[MAG_W-1:HALF_W];
      ahl5  <= a4[A_W-1:HALF_W] * cm4[HALF_W-1:0];
      alh5  <= a4[HALF_W-1:0] * cm4[MAG_W-1:HALF_W];
      all5  <= a4[HALF_W-1:0] * cm4[HALF_W-1:0];
      a5    <= a4;
      b5    <= b4;
      cneg5 <= cneg4;
      seg5  <= seg4;
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic [WIDE_W-1:0] bb6, ac6;
  logic [A_W-1:0]    a6;
  logic [B_W-1:0]    b6;
  logic              cneg6;
  scs_pkg::seg_t     seg6;

  always_ff @(posedge clk) begin
    if (ce) begin
      bb6   <= (WIDE_W'(bhh5) << (2 * HALF_W)) + (WIDE_W'(bhl5) << (HALF_W + 1))
               + WIDE_W'(bll5);
      ac6   <= (WIDE_W'(ahh5) << (2 * HALF_W)) + (WIDE_W'(ahl5) << HALF_W)
               + (WIDE_W'(alh5) << HALF_W) + WIDE_W'(all5);
      a6    <= a5;
      b6    <= b5;
      cneg6 <= cneg5;
      seg6  <= seg5;
    end
  end

  // ---------------------------------------------------------------- stage 7
  // D = b*b - a*c; negative D means the line misses the circle
  logic [WIDE_W:0]   dsum, ddif;
  logic [WIDE_W-1:0] d7;
  logic              neg7;
  logic [A_W-1:0]    a7;
  logic [B_W-1:0]    b7;
  scs_pkg::seg_t     seg7;

  always_comb begin
    dsum = {1'b0, bb6} + {1'b0, ac6};
    ddif = {1'b0, bb6} - {1'b0, ac6};
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d7   <= cneg6 ? dsum[WIDE_W-1:0] : ddif[WIDE_W-1:0];
      neg7 <= !cneg6 && ddif[WIDE_W];
      a7   <= a6;
      b7   <= b6;
      seg7 <= seg6;
    end
  end

  // ---------------------------------------------------------------- root
  scs_pkg::sq_pay_t   sq_in, sq_out;
  logic [2*ROOT_W-1:0] sq_rad;
  logic [ROOT_W-1:0]   sq_root;

  always_comb begin
    sq_in.a    = a7;
    sq_in.b    = b7;
    sq_in.neg  = neg7;
    sq_in.tang = (d7[WIDE_W-1:LIM_W] == '0) && (d7[LIM_W-1:0] < tangent_limit);
    sq_in.seg  = seg7;
    sq_rad     = neg7 ? '0 : (2*ROOT_W)'(d7);
  end

  scs_sqrt #(
    .ROOT_W (ROOT_W),
    .PAY_W  ($bits(scs_pkg::sq_pay_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (v7),
    .in_rad    (sq_rad),
    .in_pay    (sq_in),
    .out_valid (sq_vo),
    .out_root  (sq_root),
    .out_pay   (sq_out)
  );

  // ---------------------------------------------------------------- stage 8
  // numerators -b, -b - s, -b + s
  logic signed [N_W-1:0] bx, rs;
  logic signed [N_W-1:0] nb8, n18, n28;
  logic [A_W-1:0]        a8;
  logic                  neg8, tang8;
  scs_pkg::seg_t         seg8;

  always_comb begin
    bx = $signed(sq_out.b);
    rs = $signed(N_W'(sq_root));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      nb8   <= -bx;
      n18   <= -bx - rs;
      n28   <= -bx + rs;
      a8    <= sq_out.a;
      neg8  <= sq_out.neg;
      tang8 <= sq_out.tang;
      seg8  <= sq_out.seg;
    end
  end

  // ---------------------------------------------------------------- stage 9
  // pick hits: touching, crossing, or a too-short segment at 0.5
  logic signed [N_W-1:0] a_s;
  logic                  long_seg, h1, h2, sel_half;
  logic [CNT_W-1:0]      sel_cnt;
  logic [A_W-1:0]        sel_n0, sel_n1;
  logic [A_W-1:0]        n0_9, n1_9, a9;
  scs_pkg::dv_pay_t      pay9;

  always_comb begin
    a_s      = $signed(N_W'(a8));
    long_seg = a8 > A_W'(short_limit);
    h1       = n18 >= 0;
    h2       = n28 <= a_s;
    sel_cnt  = '0;
    sel_half = 1'b0;
    sel_n0   = nb8[A_W-1:0];
    sel_n1   = n28[A_W-1:0];
    if (neg8) begin
      sel_cnt = '0;
    end else if (tang8) begin
      if (nb8 >= 0 && nb8 <= a_s) begin
        sel_cnt  = CNT_W'(1);
        sel_half = !long_seg;
      end
    end else if (n18 <= a_s && n28 >= 0) begin
      if (long_seg) begin
        sel_cnt = CNT_W'(h1) + CNT_W'(h2);
        sel_n0  = h1 ? n18[A_W-1:0] : n28[A_W-1:0];
      end else begin
        sel_cnt  = CNT_W'(1);
        sel_half = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      n0_9      <= sel_n0;
      n1_9      <= sel_n1;
      a9        <= a8;
      pay9.cnt  <= sel_cnt;
      pay9.half <= sel_half;
      pay9.seg  <= seg8;
    end
  end

  // ---------------------------------------------------------------- divide
  logic [ALPHA_W-1:0] q0, q1;
  scs_pkg::dv_pay_t   dv_out;

  scs_div #(
    .NUM_W (A_W),
    .QUO_W (FRAC_W),
    .PAY_W ($bits(scs_pkg::dv_pay_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (v9),
    .in_num0   (n0_9),
    .in_num1   (n1_9),
    .in_den    (a9),
    .in_pay    (pay9),
    .out_valid (dv_vo),
    .out_q0    (q0),
    .out_q1    (q1),
    .out_pay   (dv_out)
  );

  // ---------------------------------------------------------------- stage 10
  // final alphas, zero for absent hits; alpha * d products
  logic [ALPHA_W-1:0]       alpha0, alpha1, alpha0_10, alpha1_10;
  logic signed [LERP_W-1:0] t0x, t0y, t1x, t1y;
  logic [CNT_W-1:0]         cnt10;
  logic [COORD_W-1:0]       sx10, sy10;

  always_comb begin
    alpha0 = (dv_out.cnt == '0) ? '0 : (dv_out.half ? scs_pkg::HALF_ALPHA : q0);
    alpha1 = (dv_out.cnt == CNT_W'(2)) ? q1 : '0;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      alpha0_10 <= alpha0;
      alpha1_10 <= alpha1;
      t0x       <= $signed({1'b0, alpha0}) * $signed(dv_out.seg.dx);
      t0y       <= $signed({1'b0, alpha0}) * $signed(dv_out.seg.dy);
      t1x       <= $signed({1'b0, alpha1}) * $signed(dv_out.seg.dx);
      t1y       <= $signed({1'b0, alpha1}) * $signed(dv_out.seg.dy);
      cnt10     <= dv_out.cnt;
      sx10      <= dv_out.seg.sx;
      sy10      <= dv_out.seg.sy;
    end
  end

  // ---------------------------------------------------------------- output
  // start + round_half_up(alpha * d / 2^16)
  function automatic logic [COORD_W-1:0] lerp_pt(input logic [COORD_W-1:0] s,
                                                 input logic signed [LERP_W-1:0] t);
    logic signed [LERP_W:0] tr;
    logic signed [LERP_W:0] sum;
    tr  = t;
    tr  = (tr + scs_pkg::ROUND_HALF) >>> FRAC_W;
    sum = tr + $signed(s);
    return sum[COORD_W-1:0];
  endfunction

  logic [COORD_W-1:0] fx, fy, sxo, syo;

  always_comb begin
    fx  = (cnt10 != '0) ? lerp_pt(sx10, t0x) : '0;
    fy  = (cnt10 != '0) ? lerp_pt(sy10, t0y) : '0;
    sxo = (cnt10 == CNT_W'(2)) ? lerp_pt(sx10, t1x) : '0;
    syo = (cnt10 == CNT_W'(2)) ? lerp_pt(sy10, t1y) : '0;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= {PAD_W'(0), syo, sxo, fy, fx, alpha1_10, alpha0_10, cnt10};
    end
  end

endmodule

// ===== src/scs_check.sv =====
module scs_check (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata
);

  // a stalled result word holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("hit count above two");

  // no hit: every alpha and point field is zero
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == 2'd0 |-> m_tdata[135:2] == '0)
    else $error("fields set on a word with no hit");

  // fewer than two hits: second alpha and point are zero
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != 2'd2 |->
      m_tdata[35:19] == '0 && m_tdata[131:84] == '0)
    else $error("second hit fields set without a second hit");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[18:2] <= 17'd65536 && m_tdata[35:19] <= 17'd65536)
    else $error("alpha above 1.0");

endmodule

bind segment_circle_intersection scs_check u_scs_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
